[design/tla_pkg.sv]
`default_nettype none

package tla_pkg;

    localparam int REQ_W   = 2;
    localparam int INDEX_W = 6;
    localparam int LIVE_W  = 13;

    typedef enum logic [REQ_W-1:0] {
        REQ_TOGGLE = 2'd0,
        REQ_CLEAR  = 2'd1,
        REQ_STEP   = 2'd2,
        REQ_READ   = 2'd3
    } t_req;

    // per-cycle command fanned out to every row cell
    typedef struct packed {
        logic toggle;
        logic clear;
        logic step;
        logic rotate;
        logic sum_clr;
    } t_cell_ctl;

endpackage

`default_nettype wire

[design/toroidal_life_automaton.sv]
// Toroidal life grid of ROW_COUNT x COL_COUNT cells, one row per cell of a chain.
// Input channel: i_valid / o_stall carries one request word (type, row, column).
// Output channel: o_valid / i_stall carries one result word per request: the
// addressed cell's bit and the live population after the operation.
// Toggle, clear and read: accept, execute, respond; the result is registered
// on leaving the response state, and no new request is taken before that.
// Step: the whole grid advances at once, then the population is counted by
// rotating every row once through its low bit while partial sums ripple down
// the row chain into a running total; a step request is likewise finished
// before the next request is taken.
// One request is in work at a time; o_stall is low only while the block idles.
// A finished result waits in the output register while the next request is
// already taken; its response then waits until the register frees.
// Addresses outside the grid toggle nothing and read back as dead.
// Synchronous reset clears every cell, the population and the output valid.
`default_nettype none

module toroidal_life_automaton
    import tla_pkg::*;
#(
    parameter int ROW_COUNT = 64,
    parameter int COL_COUNT = 64
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic [REQ_W-1:0]   i_req_type,
    input  wire logic [INDEX_W-1:0] i_row_index,
    input  wire logic [INDEX_W-1:0] i_col_index,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic                    o_cell_alive,
    output logic      [LIVE_W-1:0]  o_live_count
);

    localparam int SUM_W    = $clog2(ROW_COUNT + 1);
    localparam int CNT_LAST = ROW_COUNT + COL_COUNT - 1;
    localparam int CNT_W    = $clog2(CNT_LAST + 1);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_EXEC  = 4'b0010,
        ST_COUNT = 4'b0100,
        ST_RESP  = 4'b1000
    } t_state;

    t_state             r_state;
    t_state             n_state;
    t_req               r_req;
    logic [INDEX_W-1:0] r_row;
    logic [INDEX_W-1:0] r_col;
    logic               r_inside;
    logic [CNT_W-1:0]   r_cnt;
    logic [LIVE_W-1:0]  r_pop;
    logic [LIVE_W-1:0]  r_tot;
    logic [LIVE_W-1:0]  n_tot;
    logic [LIVE_W-1:0]  n_pop;
    logic               r_out_valid;
    logic               r_out_alive;
    logic [LIVE_W-1:0]  r_out_count;

    t_cell_ctl          w_ctl;
    logic [COL_COUNT-1:0] w_rows [ROW_COUNT];
    logic [SUM_W-1:0]   w_sums [ROW_COUNT];
    logic [ROW_COUNT-1:0] w_read;
    logic               w_read_bit;
    logic               w_accept;
    logic               w_out_free;
    logic               w_count_done;

    for (genvar g = 0; g < ROW_COUNT; g++) begin : g_row
        localparam int UP = (g + ROW_COUNT - 1) % ROW_COUNT;
        localparam int DN = (g + 1) % ROW_COUNT;
        logic [SUM_W-1:0] w_sum_in;
        if (g == 0) begin : g_head
            assign w_sum_in = '0;
        end else begin : g_link
            assign w_sum_in = w_sums[g-1];
        end
        tla_row_cell #(
            .COL_COUNT (COL_COUNT),
            .CELL_IDX  (g),
            .SUM_W     (SUM_W)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (w_ctl),
            .i_row_index (r_row),
            .i_col_index (r_col),
            .i_row_up    (w_rows[UP]),
            .i_row_dn    (w_rows[DN]),
            .i_sum       (w_sum_in),
            .o_row       (w_rows[g]),
            .o_sum       (w_sums[g]),
            .o_read_bit  (w_read[g])
        );
    end

    assign w_accept     = i_valid && (r_state == ST_IDLE);
    assign w_out_free   = !r_out_valid || !i_stall;
    assign w_read_bit   = r_inside && (|w_read);
    assign w_count_done = (r_cnt == CNT_W'(CNT_LAST));
    assign n_tot        = r_tot + LIVE_W'(w_sums[ROW_COUNT-1]);

    always_comb begin
        w_ctl         = '0;
        w_ctl.toggle  = (r_state == ST_EXEC) && (r_req == REQ_TOGGLE) && r_inside;
        w_ctl.clear   = (r_state == ST_EXEC) && (r_req == REQ_CLEAR);
        w_ctl.step    = (r_state == ST_EXEC) && (r_req == REQ_STEP);
        w_ctl.sum_clr = w_ctl.step;
        w_ctl.rotate  = (r_state == ST_COUNT) && (r_cnt < CNT_W'(COL_COUNT));
    end

    // population after a toggle follows the new bit of the addressed cell
    always_comb begin
        n_pop = r_pop;
        if ((r_req == REQ_TOGGLE) && r_inside) begin
            n_pop = w_read_bit ? (r_pop + LIVE_W'(1)) : (r_pop - LIVE_W'(1));
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) n_state = ST_EXEC;
            end
            ST_EXEC: begin
                n_state = (r_req == REQ_STEP) ? ST_COUNT : ST_RESP;
            end
            ST_COUNT: begin
                if (w_count_done) n_state = ST_RESP;
            end
            ST_RESP: begin
                if (w_out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_pop       <= '0;
            r_tot       <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_EXEC) begin
                r_cnt <= '0;
                r_tot <= '0;
                if (r_req == REQ_CLEAR) r_pop <= '0;
            end
            if (r_state == ST_COUNT) begin
                r_cnt <= r_cnt + CNT_W'(1);
                r_tot <= n_tot;
                if (w_count_done) r_pop <= n_tot;
            end
            if ((r_state == ST_RESP) && w_out_free) begin
                r_pop       <= n_pop;
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // request and result words carry no reset
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req    <= t_req'(i_req_type);
            r_row    <= i_row_index;
            r_col    <= i_col_index;
            r_inside <= (int'(i_row_index) < ROW_COUNT) && (int'(i_col_index) < COL_COUNT);
        end
        if ((r_state == ST_RESP) && w_out_free) begin
            r_out_alive <= w_read_bit;
            r_out_count <= n_pop;
        end
    end

    assign o_stall      = (r_state != ST_IDLE);
    assign o_valid      = r_out_valid;
    assign o_cell_alive = r_out_alive;
    assign o_live_count = r_out_count;

`ifndef NO_ASSERTIONS
    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> (r_state == ST_EXEC))
        else $error("accepted word did not enter execution");

    a_rose_from_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_state == ST_RESP))
        else $error("result word appeared outside the response state");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_COUNT) |-> (r_cnt <= CNT_W'(CNT_LAST)))
        else $error("population count ran past its last cycle");

    a_outside_dead: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_RESP) && !r_inside) |-> !w_read_bit)
        else $error("address outside the grid read as alive");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_live_count)))
        else $error("stalled result word lost or changed");
`endif

endmodule

`default_nettype wire

[design/tla_row_cell.sv]
`default_nettype none

module tla_row_cell
    import tla_pkg::*;
#(
    parameter int COL_COUNT = 64,
    parameter int CELL_IDX  = 0,
    parameter int SUM_W     = 7
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire t_cell_ctl            i_ctl,
    input  wire logic [INDEX_W-1:0]   i_row_index,
    input  wire logic [INDEX_W-1:0]   i_col_index,
    input  wire logic [COL_COUNT-1:0] i_row_up,
    input  wire logic [COL_COUNT-1:0] i_row_dn,
    input  wire logic [SUM_W-1:0]     i_sum,
    output logic      [COL_COUNT-1:0] o_row,
    output logic      [SUM_W-1:0]     o_sum,
    output logic                      o_read_bit
);

    localparam int COL_W = (COL_COUNT > 1) ? $clog2(COL_COUNT) : 1;

    logic [COL_COUNT-1:0] r_row;
    logic [COL_COUNT-1:0] n_row;
    logic [COL_COUNT-1:0] w_life;
    logic [SUM_W-1:0]     r_sum;
    logic [SUM_W-1:0]     n_sum;
    logic [COL_W-1:0]     w_col_sel;
    logic                 w_row_hit;

    assign w_col_sel = COL_W'(i_col_index);
    assign w_row_hit = (int'(i_row_index) == CELL_IDX);

    // next generation, every column wrapping at both ends
    for (genvar c = 0; c < COL_COUNT; c++) begin : g_col
        localparam int LF = (c + COL_COUNT - 1) % COL_COUNT;
        localparam int RT = (c + 1) % COL_COUNT;
        logic [3:0] w_nb;
        assign w_nb = {3'b000, i_row_up[LF]} + {3'b000, i_row_up[c]} + {3'b000, i_row_up[RT]}
                    + {3'b000, r_row[LF]} + {3'b000, r_row[RT]}
                    + {3'b000, i_row_dn[LF]} + {3'b000, i_row_dn[c]}
                    + {3'b000, i_row_dn[RT]};
        assign w_life[c] = (w_nb == 4'd3) || (r_row[c] && (w_nb == 4'd2));
    end

    always_comb begin
        n_row = r_row;
        priority if (i_ctl.clear) begin
            n_row = '0;
        end else if (i_ctl.step) begin
            n_row = w_life;
        end else if (i_ctl.toggle && w_row_hit) begin
            n_row[w_col_sel] = ~r_row[w_col_sel];
        end else if (i_ctl.rotate) begin
            // a full turn of COL_COUNT shifts leaves the row as it was
            n_row = {r_row[0], r_row[COL_COUNT-1:1]};
        end else begin
            n_row = r_row;
        end
    end

    always_comb begin
        if (i_ctl.sum_clr) begin
            n_sum = '0;
        end else begin
            n_sum = i_sum + {{(SUM_W-1){1'b0}}, (i_ctl.rotate & r_row[0])};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_sum <= '0;
        end else begin
            r_row <= n_row;
            r_sum <= n_sum;
        end
    end

    assign o_row      = r_row;
    assign o_sum      = r_sum;
    assign o_read_bit = w_row_hit & r_row[w_col_sel];

endmodule

`default_nettype wire

[verif/tb_top.sv]
`default_nettype none

module tb_top
    import tla_pkg::*;
();

    localparam int ROW_COUNT      = 64;
    localparam int COL_COUNT      = 64;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES  = ROW_COUNT + COL_COUNT + 8;

    typedef struct packed {
        logic              cell_alive;
        logic [LIVE_W-1:0] live_count;
    } t_cell_report;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic [REQ_W-1:0]   i_req_type;
    logic [INDEX_W-1:0] i_row_index;
    logic [INDEX_W-1:0] i_col_index;
    logic               o_valid;
    logic               i_stall;
    logic               o_cell_alive;
    logic [LIVE_W-1:0]  o_live_count;

    // shadow copy of the torus
    bit life_grid [ROW_COUNT][COL_COUNT];
    bit next_gen  [ROW_COUNT][COL_COUNT];
    int live_pop;

    t_cell_report pending_cell_reports[$];
    t_cell_report head_report;

    int tx_idle_pct;
    int rx_stall_pct;
    int requests_sent;
    int mismatches;
    int quiet_cycles;

    toroidal_life_automaton #(
        .ROW_COUNT(ROW_COUNT),
        .COL_COUNT(COL_COUNT)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_req_type   (i_req_type),
        .i_row_index  (i_row_index),
        .i_col_index  (i_col_index),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_cell_alive (o_cell_alive),
        .o_live_count (o_live_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int neighbor_count(input int r, input int c);
        int total;
        total = 0;
        for (int dr = -1; dr <= 1; dr++) begin
            for (int dc = -1; dc <= 1; dc++) begin
                if (dr != 0 || dc != 0)
                    total += life_grid[(r + dr + ROW_COUNT) % ROW_COUNT]
                                      [(c + dc + COL_COUNT) % COL_COUNT];
            end
        end
        return total;
    endfunction

    function automatic void predict_cell_report(input t_req kind,
                                                input logic [INDEX_W-1:0] r,
                                                input logic [INDEX_W-1:0] c);
        bit           on_grid;
        int           n;
        t_cell_report rpt;
        on_grid = (int'(r) < ROW_COUNT) && (int'(c) < COL_COUNT);
        case (kind)
            REQ_TOGGLE: begin
                if (on_grid) begin
                    life_grid[r][c] = !life_grid[r][c];
                    live_pop += life_grid[r][c] ? 1 : -1;
                end
            end
            REQ_CLEAR: begin
                foreach (life_grid[i, j]) life_grid[i][j] = 1'b0;
                live_pop = 0;
            end
            REQ_STEP: begin
                // every cell updates from the old generation
                foreach (next_gen[i, j]) begin
                    n = neighbor_count(i, j);
                    next_gen[i][j] = life_grid[i][j];
                    if (n < 2 || n > 3)
                        next_gen[i][j] = 1'b0;
                    else if (n == 3)
                        next_gen[i][j] = 1'b1;
                end
                life_grid = next_gen;
                live_pop = 0;
                foreach (life_grid[i, j]) live_pop += life_grid[i][j];
            end
            default: ;
        endcase
        rpt.cell_alive = on_grid ? life_grid[r][c] : 1'b0;
        rpt.live_count = live_pop[LIVE_W-1:0];
        pending_cell_reports = {pending_cell_reports, rpt};
    endfunction

    task automatic send_req(input t_req kind, input logic [INDEX_W-1:0] r,
                            input logic [INDEX_W-1:0] c);
        if ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_req_type  <= kind;
        i_row_index <= r;
        i_col_index <= c;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        // leave valid high: the next word, if any, replaces it in this step
        predict_cell_report(kind, r, c);
        requests_sent++;
    endtask

    task automatic wait_for_reports();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending_cell_reports.size() != 0);
    endtask

    // result side: check each word, then draw the next stall
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (pending_cell_reports.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result word: cell %0b count %0d",
                                 o_cell_alive, o_live_count);
                end else begin
                    head_report = pending_cell_reports.pop_front();
                    if (head_report.cell_alive !== o_cell_alive ||
                        head_report.live_count !== o_live_count) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: cell exp %0b got %0b, count exp %0d got %0d",
                                     head_report.cell_alive, o_cell_alive,
                                     head_report.live_count, o_live_count);
                    end
                end
            end
            i_stall <= ($urandom_range(99) < rx_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("toroidal_life_automaton verification failed");
                $finish;
            end
        end
    end

    task automatic test_corner_cells();
        send_req(REQ_READ, 0, 0);
        send_req(REQ_TOGGLE, 63, 63);
        send_req(REQ_TOGGLE, 0, 0);
        send_req(REQ_READ, 63, 63);
        send_req(REQ_TOGGLE, 63, 63);
        // lone cell starves
        send_req(REQ_STEP, 0, 0);
        send_req(REQ_TOGGLE, 42, 21);
        send_req(REQ_TOGGLE, 21, 42);
        send_req(REQ_CLEAR, 42, 21);
    endtask

    task automatic test_wrapped_blinker();
        // horizontal bar across the column seam
        send_req(REQ_TOGGLE, 0, 63);
        send_req(REQ_TOGGLE, 0, 0);
        send_req(REQ_TOGGLE, 0, 1);
        send_req(REQ_STEP, 63, 0);
        send_req(REQ_STEP, 0, 63);
        send_req(REQ_READ, 1, 0);
    endtask

    task automatic test_wrapped_block();
        send_req(REQ_CLEAR, 0, 0);
        send_req(REQ_TOGGLE, 63, 63);
        send_req(REQ_TOGGLE, 63, 0);
        send_req(REQ_TOGGLE, 0, 63);
        send_req(REQ_TOGGLE, 0, 0);
        send_req(REQ_STEP, 63, 63);
        // a fourth neighbor crowds the corner cell out
        send_req(REQ_TOGGLE, 1, 0);
        send_req(REQ_STEP, 0, 0);
    endtask

    task automatic test_random_colonies(input int tx_pct, input int rx_pct,
                                        input int item_goal);
        int                 stop_at;
        logic [INDEX_W-1:0] base_r;
        logic [INDEX_W-1:0] base_c;
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
        stop_at      = requests_sent + item_goal;
        while (requests_sent < stop_at) begin
            if ($urandom_range(99) < 80) begin
                // seed a small window, possibly straddling a seam, then evolve it
                base_r = INDEX_W'($urandom_range(0, 63));
                base_c = INDEX_W'($urandom_range(0, 63));
                repeat ($urandom_range(4, 14))
                    send_req(REQ_TOGGLE, INDEX_W'(base_r + $urandom_range(0, 7)),
                             INDEX_W'(base_c + $urandom_range(0, 7)));
                repeat ($urandom_range(1, 4)) begin
                    send_req(REQ_STEP, INDEX_W'(base_r + $urandom_range(0, 7)),
                             INDEX_W'(base_c + $urandom_range(0, 7)));
                    repeat ($urandom_range(0, 2))
                        send_req(REQ_READ, INDEX_W'(base_r + $urandom_range(0, 7)),
                                 INDEX_W'(base_c + $urandom_range(0, 7)));
                end
                if ($urandom_range(5) == 0)
                    send_req(REQ_CLEAR, INDEX_W'($urandom_range(0, 63)),
                             INDEX_W'($urandom_range(0, 63)));
            end else begin
                repeat ($urandom_range(1, 4))
                    send_req(t_req'($urandom_range(0, 3)), INDEX_W'($urandom_range(0, 63)),
                             INDEX_W'($urandom_range(0, 63)));
            end
        end
        wait_for_reports();
    endtask

    initial begin
        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_req_type  <= REQ_READ;
        i_row_index <= '0;
        i_col_index <= '0;
        i_stall     <= 1'b0;
        tx_idle_pct  = 31;
        rx_stall_pct = 87;
        requests_sent = 0;
        mismatches    = 0;
        quiet_cycles  = 0;
        live_pop      = 0;
        foreach (life_grid[i, j]) life_grid[i][j] = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_corner_cells();
        test_wrapped_blinker();
        test_wrapped_block();
        wait_for_reports();
        test_random_colonies(31, 87, 160);
        test_random_colonies(87, 31, 160);
        test_random_colonies(0, 0, 160);

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && pending_cell_reports.size() == 0)
            $display("toroidal_life_automaton verification clean");
        else
            $display("toroidal_life_automaton verification failed");
        $finish;
    end

endmodule

`default_nettype wire

[toroidal_life_automaton.f]
design/tla_pkg.sv
design/tla_row_cell.sv
design/toroidal_life_automaton.sv
verif/tb_top.sv
